>>> hdl/tlkbh_pkg.sv
// shared types, constants and hash functions for the three-lane keyed byte hash
`default_nettype none
package tlkbh_pkg;

    localparam logic [31:0] GOLDEN_C  = 32'h9e3779b9;
    localparam logic [31:0] KEY_C     = 32'h85ebca6b;
    localparam logic [31:0] FNV_INIT  = 32'h811c9dc5;
    localparam logic [31:0] FNV_PRIME = 32'h01000193;
    localparam logic [31:0] LANE1_C   = 32'h12345678;
    localparam logic [31:0] LANE2_C   = 32'h87654321;

    localparam logic [2:0] ADDR_SEED = 3'd0;

    typedef struct packed {
        logic       has_byte;
        logic       ends;
        logic [7:0] data;
    } item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PS_KEY,
        PS_CLR,
        PS_SCAT,
        PS_FNV1,
        PS_XFORM,
        PS_FNV2,
        PS_FOLD
    } pass_t;

    function automatic logic [31:0] xsh(input logic [31:0] v);
        logic [31:0] t;
        t = v ^ (v << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

    function automatic logic [31:0] kmix(input logic [31:0] v, input logic [31:0] k);
        logic [31:0] t;
        t = k + GOLDEN_C + (v << 6) + (v >> 2);
        return xsh(v ^ t);
    endfunction

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] d);
        logic [31:0] t;
        t = h ^ {24'd0, d};
        return t * FNV_PRIME;
    endfunction

endpackage
`default_nettype wire

>>> hdl/three_lane_keyed_byte_hash.sv
// top level: seed register on the apb port, front queue and hash engine
// each accepted byte enters the queue; the end item of a message that is not empty and
// fits MAX_LEN then starts six passes per lane over work memories with one registered
// read per cycle, plus a fold pass over all three lanes, before the result is valid
// throughput: bytes load one per cycle while the engine is idle; one message is hashed at a time
// reset: asynchronous active low; clears the seed, counts and handshakes, memories keep data
`default_nettype none
module three_lane_keyed_byte_hash
    import tlkbh_pkg::*;
#(
    parameter int MAX_LEN = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    input  wire logic        s_tuser,   // [0] empty_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [30:0] hash_value, [31] status
);

    logic [31:0] seed_reg, seed_next;
    logic        q_valid;
    item_t       q_item;
    logic        q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == ADDR_SEED[2]) ? seed_reg : 32'd0;

    always_comb
    begin
        seed_next = seed_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == ADDR_SEED[2]))
        begin
            seed_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd0;
        end
        else
        begin
            seed_reg <= seed_next;
        end
    end

    tlkbh_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    tlkbh_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .seed     (seed_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

>>> hdl/tlkbh_front.sv
// front end: accepts stream items, classifies them and queues them for the engine
`default_nettype none
module tlkbh_front
    import tlkbh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] data_byte
    input  wire logic       s_tlast,
    input  wire logic       s_tuser,   // [0] empty_message
    output logic            q_valid,
    output item_t           q_item,
    input  wire logic       q_pop
);

    item_t      entry_reg [2];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    item_t      in_item;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = entry_reg[rp_reg];

    always_comb
    begin
        in_item.has_byte = !s_tuser;
        in_item.ends     = s_tlast || s_tuser;
        in_item.data     = s_tdata;
    end

    always_comb
    begin
        wp_next  = push ? !wp_reg : wp_reg;
        rp_next  = q_pop ? !rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wp_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

>>> hdl/tlkbh_back.sv
// back end: message store, lane passes over the work memories, fold and result register
`default_nettype none
module tlkbh_back
    import tlkbh_pkg::*;
#(
    parameter int MAX_LEN = 256
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_valid,
    input  wire item_t       q_item,
    output logic             q_pop,
    input  wire logic [31:0] seed,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata
);

    localparam int NW      = $clog2(MAX_LEN + 1);
    localparam int CW      = $clog2(3 * MAX_LEN + 1);
    localparam int MSG_AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LANE_AW = $clog2(3 * MAX_LEN);
    localparam int LANE_D  = 3 * MAX_LEN;

    logic [7:0] msg_mem  [MAX_LEN];
    logic [7:0] scat_mem [MAX_LEN];
    logic [7:0] lane_mem [LANE_D];

    state_t      st_reg, st_next;
    pass_t       pass_reg, pass_next;
    logic [NW-1:0] len_reg, len_next;
    logic          ovf_reg, ovf_next;
    logic [NW-1:0] n_reg, n_next;
    logic [1:0]    lane_reg, lane_next;
    logic [CW-1:0] base_reg, base_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] pi_reg, pi_next;
    logic          pv_reg, pv_next;
    logic [NW-1:0] tgt_reg, tgt_next;
    logic [31:0]   k_reg, k_next;
    logic [31:0]   h_reg, h_next;
    logic [31:0]   x_reg, x_next;
    logic [31:0]   a_reg, a_next;
    logic [31:0]   hl_reg [3];
    logic [31:0]   hl_next [3];
    logic [30:0]   res_hash_reg, res_hash_next;
    logic          res_stat_reg, res_stat_next;
    logic          ov_reg, ov_next;
    logic [31:0]   od_reg, od_next;

    logic [7:0] msg_q, scat_q, lane_q;
    logic               msg_we, scat_we, lane_we;
    logic [MSG_AW-1:0]  msg_wa, msg_ra, scat_wa, scat_ra;
    logic [LANE_AW-1:0] lane_wa, lane_ra;
    logic [7:0]         msg_wd, scat_wd, lane_wd;

    logic [CW-1:0] plen;
    logic          issue;
    logic          pass_done;
    logic          ovf_now;
    logic [NW-1:0] len_now;
    logic          start_run;
    logic [31:0]   ls;
    logic [31:0]   ls_next_lane;
    logic [31:0]   kn;
    logic [CW-1:0] swp;
    logic [NW+2:0] tv;

    assign plen      = (pass_reg == PS_FOLD) ? CW'(3 * n_reg) : CW'(n_reg);
    assign issue     = (st_reg == ST_RUN) && (cnt_reg < plen);
    assign pass_done = (st_reg == ST_RUN) && (cnt_reg == plen) && !pv_reg;
    assign kn        = kmix(k_reg, 32'(pi_reg));

    always_comb
    begin
        case (lane_reg)
            2'd1:    ls = seed ^ LANE1_C;
            2'd2:    ls = seed ^ LANE2_C;
            default: ls = seed;
        endcase
        case (lane_reg)
            2'd0:    ls_next_lane = seed ^ LANE1_C;
            default: ls_next_lane = seed ^ LANE2_C;
        endcase
    end

    // arrival of a queued item
    always_comb
    begin
        ovf_now   = ovf_reg || (q_item.has_byte && (len_reg == NW'(MAX_LEN)));
        len_now   = len_reg;
        if (q_item.has_byte && (len_reg < NW'(MAX_LEN)))
        begin
            len_now = len_reg + NW'(1);
        end
        start_run = !ovf_now && (len_now != '0);
    end

    // next scatter target, (t + 5) mod n with five conditional subtracts
    always_comb
    begin
        tv = {3'd0, tgt_reg} + (NW+3)'(5);
        for (int s = 0; s < 5; s++)
        begin
            if (tv >= {3'd0, n_reg})
            begin
                tv = tv - {3'd0, n_reg};
            end
        end
    end

    always_comb
    begin
        swp = cnt_reg ^ CW'(1);
        if (swp >= CW'(n_reg))
        begin
            swp = cnt_reg;
        end
    end

    // next state
    always_comb
    begin
        st_next   = st_reg;
        pass_next = pass_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (q_valid && q_item.ends)
                begin
                    st_next   = start_run ? ST_RUN : ST_DONE;
                    pass_next = PS_KEY;
                end
            end
            ST_RUN:
            begin
                if (pass_done)
                begin
                    case (pass_reg)
                        PS_KEY:   pass_next = PS_CLR;
                        PS_CLR:   pass_next = PS_SCAT;
                        PS_SCAT:  pass_next = PS_FNV1;
                        PS_FNV1:  pass_next = PS_XFORM;
                        PS_XFORM: pass_next = PS_FNV2;
                        PS_FNV2:  pass_next = (lane_reg == 2'd2) ? PS_FOLD : PS_KEY;
                        PS_FOLD:  st_next   = ST_DONE;
                        default:  pass_next = PS_KEY;
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    st_next = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        q_pop         = (st_reg == ST_IDLE) && q_valid;
        len_next      = len_reg;
        ovf_next      = ovf_reg;
        n_next        = n_reg;
        lane_next     = lane_reg;
        base_next     = base_reg;
        cnt_next      = cnt_reg;
        pi_next       = cnt_reg;
        pv_next       = issue;
        tgt_next      = tgt_reg;
        k_next        = k_reg;
        h_next        = h_reg;
        x_next        = x_reg;
        a_next        = a_reg;
        hl_next       = hl_reg;
        res_hash_next = res_hash_reg;
        res_stat_next = res_stat_reg;
        ov_next       = ov_reg && !m_tready;
        od_next       = od_reg;

        msg_we  = 1'b0;
        msg_wa  = len_reg[MSG_AW-1:0];
        msg_wd  = q_item.data;
        msg_ra  = cnt_reg[MSG_AW-1:0];
        scat_we = 1'b0;
        scat_wa = pi_reg[MSG_AW-1:0];
        scat_wd = 8'd0;
        scat_ra = cnt_reg[MSG_AW-1:0];
        lane_we = 1'b0;
        lane_wa = LANE_AW'(base_reg + pi_reg);
        lane_wd = 8'd0;
        lane_ra = LANE_AW'(base_reg + cnt_reg);

        if (pass_reg == PS_SCAT)
        begin
            lane_ra = LANE_AW'(base_reg + swp);
        end
        else if (pass_reg == PS_FOLD)
        begin
            lane_ra = LANE_AW'(cnt_reg);
        end

        if (issue)
        begin
            cnt_next = cnt_reg + CW'(1);
        end

        case (st_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    msg_we   = q_item.has_byte && (len_reg < NW'(MAX_LEN));
                    len_next = len_now;
                    ovf_next = ovf_now;
                    if (q_item.ends)
                    begin
                        len_next      = '0;
                        ovf_next      = 1'b0;
                        n_next        = len_now;
                        lane_next     = 2'd0;
                        base_next     = '0;
                        cnt_next      = '0;
                        pv_next       = 1'b0;
                        k_next        = seed ^ KEY_C;
                        res_hash_next = '0;
                        res_stat_next = ovf_now;
                    end
                end
            end
            ST_RUN:
            begin
                if (pv_reg)
                begin
                    case (pass_reg)
                        PS_KEY:
                        begin
                            k_next  = kn;
                            lane_we = 1'b1;
                            lane_wd = msg_q ^ kn[7:0];
                        end
                        PS_CLR:
                        begin
                            scat_we = 1'b1;
                        end
                        PS_SCAT:
                        begin
                            scat_we  = 1'b1;
                            scat_wa  = tgt_reg[MSG_AW-1:0];
                            scat_wd  = lane_q;
                            tgt_next = tv[NW-1:0];
                        end
                        PS_FNV1:
                        begin
                            h_next = fnv_step(h_reg, scat_q);
                        end
                        PS_XFORM:
                        begin
                            lane_we = 1'b1;
                            lane_wa = LANE_AW'(base_reg + CW'(n_reg) - CW'(1) - pi_reg);
                            lane_wd = (scat_q + x_reg[7:0]) ^ x_reg[15:8];
                            x_next  = xsh(x_reg);
                        end
                        PS_FNV2:
                        begin
                            h_next = fnv_step(h_reg, lane_q);
                        end
                        PS_FOLD:
                        begin
                            k_next = kn;
                            a_next = xsh(a_reg ^ {24'd0, lane_q ^ kn[7:0]});
                        end
                        default:
                        begin
                            k_next = k_reg;
                        end
                    endcase
                end
                if (pass_done)
                begin
                    cnt_next = '0;
                    pv_next  = 1'b0;
                    case (pass_reg)
                        PS_CLR:
                        begin
                            tgt_next = (n_reg == NW'(1)) ? '0 : NW'(1);
                        end
                        PS_SCAT:
                        begin
                            h_next = FNV_INIT;
                        end
                        PS_FNV1:
                        begin
                            x_next = h_reg ^ ls;
                        end
                        PS_XFORM:
                        begin
                            h_next = FNV_INIT;
                        end
                        PS_FNV2:
                        begin
                            hl_next[lane_reg] = h_reg;
                            if (lane_reg == 2'd2)
                            begin
                                k_next = hl_reg[0] ^ (hl_reg[1] << 1) ^ (h_reg >> 1);
                                a_next = '0;
                            end
                            else
                            begin
                                lane_next = lane_reg + 2'd1;
                                base_next = base_reg + CW'(n_reg);
                                k_next    = ls_next_lane ^ KEY_C;
                            end
                        end
                        PS_FOLD:
                        begin
                            res_hash_next = a_reg[30:0];
                            res_stat_next = 1'b0;
                        end
                        default:
                        begin
                            tgt_next = tgt_reg;
                        end
                    endcase
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1;
                    od_next = {res_stat_reg, res_hash_reg};
                end
            end
            default:
            begin
                ov_next = ov_reg && !m_tready;
            end
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            pass_reg <= PS_KEY;
            len_reg  <= '0;
            ovf_reg  <= 1'b0;
            lane_reg <= 2'd0;
            cnt_reg  <= '0;
            pv_reg   <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            pass_reg <= pass_next;
            len_reg  <= len_next;
            ovf_reg  <= ovf_next;
            lane_reg <= lane_next;
            cnt_reg  <= cnt_next;
            pv_reg   <= pv_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        base_reg     <= base_next;
        pi_reg       <= pi_next;
        tgt_reg      <= tgt_next;
        k_reg        <= k_next;
        h_reg        <= h_next;
        x_reg        <= x_next;
        a_reg        <= a_next;
        hl_reg       <= hl_next;
        res_hash_reg <= res_hash_next;
        res_stat_reg <= res_stat_next;
        od_reg       <= od_next;
    end

    always_ff @(posedge clk)
    begin
        if (msg_we)
        begin
            msg_mem[msg_wa] <= msg_wd;
        end
        msg_q <= msg_mem[msg_ra];
    end

    always_ff @(posedge clk)
    begin
        if (scat_we)
        begin
            scat_mem[scat_wa] <= scat_wd;
        end
        scat_q <= scat_mem[scat_ra];
    end

    always_ff @(posedge clk)
    begin
        if (lane_we)
        begin
            lane_mem[lane_wa] <= lane_wd;
        end
        lane_q <= lane_mem[lane_ra];
    end

endmodule
`default_nettype wire

>>> hdl/tlkbh_checker.sv
// port-level checks for the three-lane keyed byte hash, bound to the top level
`default_nettype none
module tlkbh_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        pready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an error result carries a zero hash
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[31] |-> (m_tdata[30:0] == 31'd0))
        else $error("error result with nonzero hash");

    // config port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind three_lane_keyed_byte_hash tlkbh_checker u_tlkbh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .pready   (pready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
